// ===== sv/kps_pkg.sv =====
// shared constants, types and key table for the keypad scanner
package kps_pkg;

   localparam int ROW_COUNT          = 4;
   localparam int COL_COUNT          = 4;
   localparam int ROW_IDX_W          = $clog2(ROW_COUNT);
   localparam int COL_IDX_W          = $clog2(COL_COUNT);
   localparam int KEY_CODE_W         = 4;
   localparam int TIMER_BITS_DEFAULT = 16;

   localparam int CSR_DATA_W  = 16;
   localparam int CSR_INDEX_W = 1;

   localparam logic [CSR_INDEX_W-1:0] REG_COLUMN_DWELL = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] REG_HOLDOFF      = 1'd1;

   localparam logic [CSR_DATA_W-1:0] COLUMN_DWELL_RESET = 16'd25;
   localparam logic [CSR_DATA_W-1:0] HOLDOFF_RESET      = 16'd100;

   localparam logic [KEY_CODE_W-1:0] KEY_A = 4'hA;
   localparam logic [KEY_CODE_W-1:0] KEY_B = 4'hB;
   localparam logic [KEY_CODE_W-1:0] KEY_C = 4'hC;
   localparam logic [KEY_CODE_W-1:0] KEY_D = 4'hD;
   localparam logic [KEY_CODE_W-1:0] KEY_E = 4'hE;
   localparam logic [KEY_CODE_W-1:0] KEY_F = 4'hF;

   // printed legend of the hex keypad, [row][column]
   localparam logic [KEY_CODE_W-1:0] PAD_CODE [ROW_COUNT][COL_COUNT] = '{
      '{4'h1, 4'h2, 4'h3, KEY_C},
      '{4'h4, 4'h5, 4'h6, KEY_D},
      '{4'h7, 4'h8, 4'h9, KEY_E},
      '{KEY_A, 4'h0, KEY_B, KEY_F}
   };

   typedef struct packed {
      logic                 pending;
      logic                 new_key;
      logic [ROW_IDX_W-1:0] row;
      logic [COL_IDX_W-1:0] col;
   } key_state_type;

endpackage

// ===== sv/kps_if.sv =====
// valid/ready channels for tick words and scan result words
interface kps_req_if;
   logic                         valid;
   logic                         ready;
   logic [kps_pkg::ROW_COUNT-1:0] row_rise;
   logic                         take_key;

   modport source (output valid, output row_rise, output take_key, input ready);
   modport sink   (input valid, input row_rise, input take_key, output ready);
endinterface

interface kps_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [kps_pkg::COL_COUNT-1:0]  column_drive;
   logic                          key_pending;
   logic                          new_key;
   logic [kps_pkg::ROW_IDX_W-1:0]  key_row;
   logic [kps_pkg::COL_IDX_W-1:0]  key_col;
   logic [kps_pkg::KEY_CODE_W-1:0] key_code;

   modport source (output valid, output column_drive, output key_pending, output new_key,
                   output key_row, output key_col, output key_code, input ready);
   modport sink   (input valid, input column_drive, input key_pending, input new_key,
                   input key_row, input key_col, input key_code, output ready);
endinterface

// ===== sv/kps_cfg_regs.sv =====
// configuration registers with saturation to the timer width
module kps_cfg_regs #(
   parameter int TIMER_BITS = kps_pkg::TIMER_BITS_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_write_enable,
   input  logic [kps_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [kps_pkg::CSR_DATA_W-1:0]     csr_write_data,
   output logic [TIMER_BITS-1:0]              dwell_ticks,
   output logic [TIMER_BITS-1:0]              holdoff_ticks
);
   import kps_pkg::*;

   localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

   logic [CSR_DATA_W-1:0] dwell_ff;
   logic [CSR_DATA_W-1:0] dwell_in;
   logic [CSR_DATA_W-1:0] holdoff_ff;
   logic [CSR_DATA_W-1:0] holdoff_in;

   always_comb begin
      dwell_in   = dwell_ff;
      holdoff_in = holdoff_ff;
      if (csr_write_enable) begin
         case (csr_index)
            REG_COLUMN_DWELL: dwell_in   = csr_write_data;
            REG_HOLDOFF:      holdoff_in = csr_write_data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dwell_ff   <= COLUMN_DWELL_RESET;
         holdoff_ff <= HOLDOFF_RESET;
      end else begin
         dwell_ff   <= dwell_in;
         holdoff_ff <= holdoff_in;
      end
   end

   // values beyond the counter range clamp to its maximum
   assign dwell_ticks   = (33'(dwell_ff) > 33'(TMAX)) ? TMAX : TIMER_BITS'(dwell_ff);
   assign holdoff_ticks = (33'(holdoff_ff) > 33'(TMAX)) ? TMAX : TIMER_BITS'(holdoff_ff);

endmodule

// ===== sv/kps_col_scan.sv =====
// column rotation with dwell counter
module kps_col_scan #(
   parameter int TIMER_BITS = kps_pkg::TIMER_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step,
   input  logic [TIMER_BITS-1:0]           dwell_ticks,
   output logic [kps_pkg::COL_IDX_W-1:0]   active_col
);
   import kps_pkg::*;

   logic [TIMER_BITS-1:0] count_ff;
   logic [TIMER_BITS-1:0] count_in;
   logic [COL_IDX_W-1:0]  col_ff;
   logic [COL_IDX_W-1:0]  col_in;
   logic [TIMER_BITS-1:0] dwell_eff;
   logic [TIMER_BITS-1:0] count_next;
   logic                  wrap;

   always_comb begin
      // zero dwell behaves as one tick per column
      dwell_eff  = (dwell_ticks == '0) ? TIMER_BITS'(1) : dwell_ticks;
      count_next = count_ff + 1'b1;
      wrap       = (count_next >= dwell_eff) || (count_next == '0);
      count_in   = count_ff;
      col_in     = col_ff;
      if (step) begin
         count_in = wrap ? '0 : count_next;
         col_in   = wrap ? col_ff + 1'b1 : col_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         col_ff   <= '0;
      end else begin
         count_ff <= count_in;
         col_ff   <= col_in;
      end
   end

   assign active_col = col_ff;

   a_col_moves_on_wrap: assert property (@(posedge clock) disable iff (reset)
      step |=> (col_ff == $past(col_ff)) || (count_ff == '0))
      else $error("column advanced without dwell counter wrap");

endmodule

// ===== sv/kps_row_debounce.sv =====
// per-row hold-off counters, winner select and key latch
module kps_row_debounce #(
   parameter int TIMER_BITS = kps_pkg::TIMER_BITS_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            step,
   input  logic [kps_pkg::ROW_COUNT-1:0]   row_rise,
   input  logic                            take_key,
   input  logic [kps_pkg::COL_IDX_W-1:0]   active_col,
   input  logic [TIMER_BITS-1:0]           holdoff_ticks,
   output kps_pkg::key_state_type          key_state
);
   import kps_pkg::*;

   logic [TIMER_BITS-1:0] holdoff_ff [ROW_COUNT];
   logic [TIMER_BITS-1:0] holdoff_in [ROW_COUNT];
   logic                  pending_ff;
   logic                  pending_in;
   logic [ROW_IDX_W-1:0]  row_ff;
   logic [ROW_IDX_W-1:0]  row_in;
   logic [COL_IDX_W-1:0]  col_ff;
   logic [COL_IDX_W-1:0]  col_in;
   logic                  accepted;
   logic [ROW_IDX_W-1:0]  win_row;

   always_comb begin
      accepted = 1'b0;
      win_row  = '0;
      // scan downwards so the lowest row ends up as winner
      for (int r = ROW_COUNT - 1; r >= 0; r--) begin
         if (row_rise[r] && (holdoff_ff[r] == '0)) begin
            accepted = 1'b1;
            win_row  = ROW_IDX_W'(r);
         end
      end
      for (int r = 0; r < ROW_COUNT; r++) begin
         holdoff_in[r] = holdoff_ff[r];
         if (step) begin
            if (row_rise[r]) begin
               holdoff_in[r] = holdoff_ticks;
            end else if (holdoff_ff[r] != '0) begin
               holdoff_in[r] = holdoff_ff[r] - 1'b1;
            end
         end
      end
      pending_in = pending_ff;
      row_in     = row_ff;
      col_in     = col_ff;
      if (step) begin
         pending_in = accepted | (pending_ff & ~take_key);
         if (accepted) begin
            row_in = win_row;
            col_in = active_col;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int r = 0; r < ROW_COUNT; r++) begin
            holdoff_ff[r] <= '0;
         end
         pending_ff <= 1'b0;
         row_ff     <= '0;
         col_ff     <= '0;
      end else begin
         for (int r = 0; r < ROW_COUNT; r++) begin
            holdoff_ff[r] <= holdoff_in[r];
         end
         pending_ff <= pending_in;
         row_ff     <= row_in;
         col_ff     <= col_in;
      end
   end

   always_comb begin
      key_state.pending = pending_in;
      key_state.new_key = accepted;
      key_state.row     = row_in;
      key_state.col     = col_in;
   end

   a_edge_reloads: assert property (@(posedge clock) disable iff (reset)
      step && row_rise[0] |=> holdoff_ff[0] == $past(holdoff_ticks))
      else $error("row edge did not reload its hold-off");

   a_accept_needs_idle_row: assert property (@(posedge clock) disable iff (reset)
      step && accepted |-> holdoff_ff[win_row] == '0)
      else $error("key accepted on a row still in hold-off");

endmodule

// ===== sv/matrix_keypad_scanner_core.sv =====
// 4x4 keypad scanner: tick words in, one scan result word out per tick
//
// Each accepted tick word carries the row rising edges and a take strobe;
// each produces exactly one result word. The block takes one word per
// clock cycle unless back-pressure holds it: a word goes into an input
// register, and the column, hold-off and key-latch state is updated from
// it when it moves on, while the result is loaded into the output
// register. Both registers hold under back-pressure, and the input side
// keeps taking words while a result waits as long as the output register
// frees up in the same cycle. Column dwell and per-row hold-off come
// from the two registers of the csr port and are counted in ticks,
// clamped to TIMER_BITS.
module matrix_keypad_scanner_core #(
   parameter int TIMER_BITS = kps_pkg::TIMER_BITS_DEFAULT
) (
   input  logic                           clock,
   input  logic                           reset,
   kps_req_if.sink                        req_chan,
   kps_rsp_if.source                      rsp_chan,
   input  logic                           csr_write_enable,
   input  logic [kps_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [kps_pkg::CSR_DATA_W-1:0]  csr_write_data
);
   import kps_pkg::*;

   logic [TIMER_BITS-1:0] dwell_ticks;
   logic [TIMER_BITS-1:0] holdoff_ticks;
   logic [COL_IDX_W-1:0]  active_col;
   key_state_type         key_state;

   logic                  in_valid_ff;
   logic                  in_valid_in;
   logic [ROW_COUNT-1:0]  in_rise_ff;
   logic                  in_take_ff;
   logic                  out_valid_ff;
   logic                  out_valid_in;
   logic [COL_COUNT-1:0]  drive_ff;
   logic                  pending_ff;
   logic                  new_key_ff;
   logic [ROW_IDX_W-1:0]  row_ff;
   logic [COL_IDX_W-1:0]  col_ff;
   logic [KEY_CODE_W-1:0] code_ff;
   logic                  advance;
   logic                  req_take;

   kps_cfg_regs #(.TIMER_BITS(TIMER_BITS)) u_cfg (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .dwell_ticks      (dwell_ticks),
      .holdoff_ticks    (holdoff_ticks)
   );

   kps_col_scan #(.TIMER_BITS(TIMER_BITS)) u_col (
      .clock       (clock),
      .reset       (reset),
      .step        (advance),
      .dwell_ticks (dwell_ticks),
      .active_col  (active_col)
   );

   kps_row_debounce #(.TIMER_BITS(TIMER_BITS)) u_rows (
      .clock         (clock),
      .reset         (reset),
      .step          (advance),
      .row_rise      (in_rise_ff),
      .take_key      (in_take_ff),
      .active_col    (active_col),
      .holdoff_ticks (holdoff_ticks),
      .key_state     (key_state)
   );

   // a held word moves on when the output register is empty or being drained
   assign advance        = in_valid_ff & (~out_valid_ff | rsp_chan.ready);
   assign req_chan.ready = ~in_valid_ff | advance;
   assign req_take       = req_chan.valid & req_chan.ready;
   assign in_valid_in    = req_take | (in_valid_ff & ~advance);
   assign out_valid_in   = advance | (out_valid_ff & ~rsp_chan.ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         in_rise_ff <= req_chan.row_rise;
         in_take_ff <= req_chan.take_key;
      end
      if (advance) begin
         drive_ff   <= COL_COUNT'(1) << active_col;
         pending_ff <= key_state.pending;
         new_key_ff <= key_state.new_key;
         row_ff     <= key_state.row;
         col_ff     <= key_state.col;
         code_ff    <= PAD_CODE[key_state.row][key_state.col];
      end
   end

   assign rsp_chan.valid        = out_valid_ff;
   assign rsp_chan.column_drive = drive_ff;
   assign rsp_chan.key_pending  = pending_ff;
   assign rsp_chan.new_key      = new_key_ff;
   assign rsp_chan.key_row      = row_ff;
   assign rsp_chan.key_col      = col_ff;
   assign rsp_chan.key_code     = code_ff;

   a_new_key_pending: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> !new_key_ff || pending_ff)
      else $error("new key shown without pending flag");

   a_drive_onehot: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff |-> $onehot(drive_ff))
      else $error("column drive not one-hot");

   a_no_step_when_blocked: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && !rsp_chan.ready |-> !advance)
      else $error("state stepped while result word was stalled");

endmodule

// ===== dv/kps_scan_checker.sv =====
`timescale 1ns / 100ps
// keypad scanner checker: predicts each result word from the tick words and compares
module kps_scan_checker (
   input  logic                            clock,
   input  logic                            reset,
   kps_req_if                              req_chan,
   kps_rsp_if                              rsp_chan,
   input  logic                            csr_write_enable,
   input  logic [kps_pkg::CSR_INDEX_W-1:0] csr_index,
   input  logic [kps_pkg::CSR_DATA_W-1:0]  csr_write_data,
   output int                              error_count,
   output int                              words_in_flight
);
   import kps_pkg::*;

   typedef struct packed {
      logic [COL_COUNT-1:0]  column_drive;
      logic                  key_pending;
      logic                  new_key;
      logic [ROW_IDX_W-1:0]  key_row;
      logic [COL_IDX_W-1:0]  key_col;
      logic [KEY_CODE_W-1:0] key_code;
   } scan_word_type;

   localparam int REPORT_LIMIT = 10;

   // keypad legend, [row][column]
   localparam logic [KEY_CODE_W-1:0] KEY_LEGEND [ROW_COUNT][COL_COUNT] = '{
      '{4'h1, 4'h2, 4'h3, KEY_C},
      '{4'h4, 4'h5, 4'h6, KEY_D},
      '{4'h7, 4'h8, 4'h9, KEY_E},
      '{KEY_A, 4'h0, KEY_B, KEY_F}
   };

   logic [CSR_DATA_W-1:0] dwell_setting;
   logic [CSR_DATA_W-1:0] holdoff_setting;
   logic [CSR_DATA_W-1:0] dwell_count;
   logic [COL_IDX_W-1:0]  active_col;
   logic [CSR_DATA_W-1:0] row_timer [ROW_COUNT];
   logic                  key_waiting;
   logic [ROW_IDX_W-1:0]  held_row;
   logic [COL_IDX_W-1:0]  held_col;

   scan_word_type due_words [$];

   initial begin
      error_count     = 0;
      words_in_flight = 0;
   end

   task automatic clear_scan_state();
      int r;
      dwell_setting   = COLUMN_DWELL_RESET;
      holdoff_setting = HOLDOFF_RESET;
      dwell_count     = '0;
      active_col      = '0;
      for (r = 0; r < ROW_COUNT; r++) row_timer[r] = '0;
      key_waiting = 1'b0;
      held_row    = '0;
      held_col    = '0;
   endtask

   task automatic advance_scan(input logic [ROW_COUNT-1:0] rise, input logic take,
                               output scan_word_type word);
      logic                  accepted;
      logic [COL_IDX_W-1:0]  col;
      logic [CSR_DATA_W-1:0] dwell;
      int                    r;
      accepted = 1'b0;
      col      = active_col;
      dwell    = (dwell_setting == '0) ? 16'd1 : dwell_setting;
      // take clears first, so a key accepted in the same tick stays pending
      if (take) key_waiting = 1'b0;
      for (r = 0; r < ROW_COUNT; r++) begin
         if (rise[r]) begin
            if (row_timer[r] == '0 && !accepted) begin
               accepted    = 1'b1;
               held_row    = r[ROW_IDX_W-1:0];
               held_col    = col;
               key_waiting = 1'b1;
            end
            row_timer[r] = holdoff_setting;
         end else if (row_timer[r] != '0) begin
            row_timer[r] = row_timer[r] - 1'b1;
         end
      end
      dwell_count = dwell_count + 1'b1;
      if (dwell_count >= dwell || dwell_count == '0) begin
         dwell_count = '0;
         active_col  = active_col + 1'b1;
      end
      word.column_drive = 4'b0001 << col;
      word.key_pending  = key_waiting;
      word.new_key      = accepted;
      word.key_row      = held_row;
      word.key_col      = held_col;
      word.key_code     = KEY_LEGEND[held_row][held_col];
   endtask

   always @(posedge clock) begin
      scan_word_type want;
      scan_word_type got;
      if (reset) begin
         clear_scan_state();
         due_words.delete();
      end else begin
         // compare before queueing, a word cannot come out in the cycle it goes in
         if (rsp_chan.valid && rsp_chan.ready) begin
            got.column_drive = rsp_chan.column_drive;
            got.key_pending  = rsp_chan.key_pending;
            got.new_key      = rsp_chan.new_key;
            got.key_row      = rsp_chan.key_row;
            got.key_col      = rsp_chan.key_col;
            got.key_code     = rsp_chan.key_code;
            if (due_words.size() == 0) begin
               error_count++;
               if (error_count <= REPORT_LIMIT)
                  $display("%0t: unexpected result word: drive %b pend %b new %b row %0d col %0d code %h",
                           $realtime, got.column_drive, got.key_pending, got.new_key,
                           got.key_row, got.key_col, got.key_code);
            end else begin
               want = due_words.pop_front();
               if (got.column_drive !== want.column_drive || got.key_pending !== want.key_pending ||
                   got.new_key !== want.new_key || got.key_row !== want.key_row ||
                   got.key_col !== want.key_col || got.key_code !== want.key_code) begin
                  error_count++;
                  if (error_count <= REPORT_LIMIT)
                     $display("%0t: mismatch: expected drive %b pend %b new %b row %0d col %0d code %h, got drive %b pend %b new %b row %0d col %0d code %h",
                              $realtime, want.column_drive, want.key_pending, want.new_key,
                              want.key_row, want.key_col, want.key_code,
                              got.column_drive, got.key_pending, got.new_key,
                              got.key_row, got.key_col, got.key_code);
               end
            end
         end
         if (req_chan.valid && req_chan.ready) begin
            advance_scan(req_chan.row_rise, req_chan.take_key, want);
            due_words.push_back(want);
         end
         if (csr_write_enable) begin
            case (csr_index)
               REG_COLUMN_DWELL: dwell_setting = csr_write_data;
               REG_HOLDOFF:      holdoff_setting = csr_write_data;
               default: ;
            endcase
         end
      end
      words_in_flight = due_words.size();
   end

endmodule

// ===== dv/tb_top.sv =====
`timescale 1ns / 100ps
// testbench top: clock, reset, tick word stimulus, result back-pressure and verdict
module tb_top;
   import kps_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int LONG_HOLD   = 60;
   localparam int TAIL_CYCLES = 8;
   localparam int PHASE_ITEMS = 215;
   localparam int PHASES      = 9;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = REG_COLUMN_DWELL;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;

   int error_count;
   int words_in_flight;
   int cycle_count = 0;
   int ticks_sent  = 0;
   bit no_idle = 1'b0;
   bit burst   = 1'b0;
   bit long_hold_request = 1'b0;

   kps_req_if req_chan ();
   kps_rsp_if rsp_chan ();

   matrix_keypad_scanner_core dut (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   kps_scan_checker scan_check (
      .clock            (clock),
      .reset            (reset),
      .req_chan         (req_chan),
      .rsp_chan         (rsp_chan),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .error_count      (error_count),
      .words_in_flight  (words_in_flight)
   );

   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("tb_top: done, errors");
         $finish;
      end
   end

   // result side: random stalls, plus one long hold-off when asked
   initial begin
      int wait_cycles;
      rsp_chan.ready = 1'b0;
      while (reset) @(negedge clock);
      forever begin
         if (long_hold_request) begin
            long_hold_request = 1'b0;
            wait_cycles = LONG_HOLD;
         end else begin
            wait_cycles = no_idle ? 0 : $urandom_range(0, 7);
         end
         if (wait_cycles > 0) begin
            rsp_chan.ready <= 1'b0;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_chan.ready <= 1'b1;
         do @(posedge clock); while (!rsp_chan.valid);
         @(negedge clock);
      end
   end

   // valid is only lowered when a gap follows, never dropped and raised in one step
   task automatic send_tick(input logic [ROW_COUNT-1:0] rise, input logic take);
      int gap;
      gap = (no_idle || burst) ? 0 : $urandom_range(0, 7);
      if (gap > 0) begin
         req_chan.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_chan.valid    <= 1'b1;
      req_chan.row_rise <= rise;
      req_chan.take_key <= take;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
      ticks_sent++;
   endtask

   task automatic settle();
      req_chan.valid <= 1'b0;
      while (words_in_flight != 0) @(negedge clock);
      repeat (TAIL_CYCLES) @(negedge clock);
   endtask

   task automatic write_regs(input logic [CSR_DATA_W-1:0] dwell,
                             input logic [CSR_DATA_W-1:0] holdoff);
      csr_write_enable <= 1'b1;
      csr_index        <= REG_COLUMN_DWELL;
      csr_write_data   <= dwell;
      @(negedge clock);
      csr_index        <= REG_HOLDOFF;
      csr_write_data   <= holdoff;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      @(negedge clock);
   endtask

   task automatic noise_tick();
      logic [ROW_COUNT-1:0] rise;
      int pick;
      pick = $urandom_range(0, 9);
      if (pick < 4) rise = '0;
      else if (pick < 8) rise = 4'b0001 << $urandom_range(0, 3);
      else rise = 4'($urandom_range(0, 15));
      send_tick(rise, $urandom_range(0, 3) == 0);
   endtask

   // a bouncing press on one row, then quiet long enough for a hold-off of up to 24 ticks to run out
   task automatic press_key(input logic [CSR_DATA_W-1:0] holdoff);
      logic [ROW_COUNT-1:0] rise;
      int bounces;
      int quiet;
      int take_at;
      int i;
      rise    = 4'b0001 << $urandom_range(0, 3);
      bounces = $urandom_range(1, 4);
      for (i = 0; i < bounces; i++) begin
         if ($urandom_range(0, 7) == 0) send_tick(rise | 4'($urandom_range(0, 15)), 1'b0);
         else send_tick(rise, 1'b0);
      end
      quiet   = ((holdoff > 24) ? 24 : int'(holdoff)) + $urandom_range(0, 2);
      take_at = $urandom_range(0, quiet + 2);
      for (i = 0; i < quiet; i++) send_tick('0, i == take_at);
   endtask

   initial begin
      logic [CSR_DATA_W-1:0] dwell_cfg;
      logic [CSR_DATA_W-1:0] holdoff_cfg;
      int phase;
      int r;
      int c;
      int phase_start;
      req_chan.valid    = 1'b0;
      req_chan.row_rise = '0;
      req_chan.take_key = 1'b0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // reset settings: first edge taken, repeat ignored, take, lowest free row wins
      send_tick(4'b0001, 1'b0);
      send_tick(4'b0001, 1'b0);
      send_tick(4'b0000, 1'b1);
      send_tick(4'b1111, 1'b0);
      send_tick(4'b0000, 1'b0);

      // one tick per column and no hold-off: every key of the pad
      settle();
      write_regs(16'd1, 16'd0);
      for (r = 0; r < ROW_COUNT; r++)
         for (c = 0; c < COL_COUNT; c++)
            send_tick(4'b0001 << r, c == COL_COUNT - 1);

      // zero dwell and longest hold-off
      settle();
      write_regs(16'd0, 16'hFFFF);
      send_tick(4'b1000, 1'b0);
      send_tick(4'b1000, 1'b1);
      send_tick(4'b0110, 1'b0);

      for (phase = 0; phase < PHASES; phase++) begin
         case (phase)
            0: begin dwell_cfg = 16'd1;     holdoff_cfg = 16'd0;     end
            1: begin dwell_cfg = 16'd0;     holdoff_cfg = 16'd3;     end
            2: begin dwell_cfg = 16'hFFFF;  holdoff_cfg = 16'd2;     end
            3: begin dwell_cfg = 16'd4;     holdoff_cfg = 16'hFFFF;  end
            4: begin dwell_cfg = 16'd2;     holdoff_cfg = 16'd1;     end
            5: begin
               dwell_cfg   = 16'($urandom_range(0, 8));
               holdoff_cfg = 16'($urandom_range(0, 20));
            end
            6: begin dwell_cfg = 16'd3;     holdoff_cfg = 16'd10;    end
            7: begin
               dwell_cfg   = 16'($urandom_range(1, 6));
               holdoff_cfg = 16'($urandom_range(0, 6));
            end
            default: begin dwell_cfg = 16'd25; holdoff_cfg = 16'd100; end
         endcase
         settle();
         write_regs(dwell_cfg, holdoff_cfg);
         no_idle     = (phase % 3 == 2);
         phase_start = ticks_sent;
         if (phase == 4) begin
            // result side holds off while ticks keep coming, so the input stalls
            long_hold_request = 1'b1;
            burst = 1'b1;
            repeat (30) noise_tick();
            burst = 1'b0;
         end
         while (ticks_sent - phase_start < PHASE_ITEMS) begin
            if (phase == 6 && ticks_sent - phase_start >= PHASE_ITEMS / 2 &&
                ticks_sent - phase_start < PHASE_ITEMS / 2 + 1)
               settle();
            if ($urandom_range(0, 2) != 0) press_key(holdoff_cfg);
            else noise_tick();
         end
      end

      settle();
      if (error_count == 0 && words_in_flight == 0)
         $display("tb_top: done, clean");
      else
         $display("tb_top: done, errors");
      $finish;
   end

endmodule

// ===== files.f =====
sv/kps_pkg.sv
sv/kps_if.sv
sv/kps_cfg_regs.sv
sv/kps_col_scan.sv
sv/kps_row_debounce.sv
sv/matrix_keypad_scanner_core.sv
dv/kps_scan_checker.sv
dv/tb_top.sv
